[rtl/sde_pkg.sv]
// Shared constants and types for the set difference engine.
`timescale 1ns / 1ps

package sde_pkg;

  localparam int SET_CAPACITY = 32;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CNT_W        = $clog2(SET_CAPACITY + 1);

  typedef enum logic [2:0] {
    MODE_APP_A  = 3'd0,
    MODE_APP_B  = 3'd1,
    MODE_DIFF   = 3'd2,
    MODE_SYMDIF = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_ELEM   = 2'd0,
    ST_APP_OK = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Commands from the sequencer to one set chain.
  typedef struct packed {
    logic app;
    logic rot;
    logic clr;
  } chain_ctl_t;

  // Commands from a chain to each of its cells.
  typedef struct packed {
    logic             wr;
    logic             rot;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

[rtl/set_difference_engine_top.sv]
// Set difference engine top: two cell chains, scan sequencer and output register.
// Append: result the cycle after acceptance, one per cycle unless the result side stalls;
// clear: no result. Difference scans set A, symmetric difference A then B, an empty set
// without a scan; the last result comes from the finish state, then the next transaction.
// One element is checked per cycle while the result side is free: the chain under scan
// rotates past a parallel match. One transaction in flight; result-side stalls hold the scan.
// Reset (rst, synchronous) empties both sets; element storage is not cleared.
`timescale 1ns / 1ps

module set_difference_engine_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [2:0]           mode,
  input  logic signed [31:0]   element,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic signed [31:0]   result_value,
  output logic [1:0]           status,
  output logic                 last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_FINISH
  } state_t;

  state_t                          state;
  logic                            sym;
  logic [sde_pkg::CNT_W-1:0]       j;
  logic                            pend_v;
  logic [sde_pkg::DATA_W-1:0]      pend;

  sde_pkg::chain_ctl_t             ctl_a, ctl_b;
  logic [sde_pkg::DATA_W-1:0]      a_head, b_head;
  logic [sde_pkg::CNT_W-1:0]       a_count, b_count;
  logic                            a_full, b_full, a_hit, b_hit;

  logic                            out_free;
  logic                            req_acc;
  logic                            step;
  logic                            miss;
  logic [sde_pkg::DATA_W-1:0]      cur;
  logic                            end_of_pass;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign req_acc   = req_valid && !req_stall;

  // one rotation step of the chain under scan
  always_comb begin
    step        = 1'b0;
    miss        = 1'b0;
    cur         = a_head;
    end_of_pass = 1'b0;
    unique case (state)
      S_SCAN_A: begin
        step        = out_free && (a_count != '0);
        miss        = !b_hit;
        cur         = a_head;
        end_of_pass = (j + sde_pkg::CNT_W'(1)) == a_count;
      end
      S_SCAN_B: begin
        step        = out_free && (b_count != '0);
        miss        = !a_hit;
        cur         = b_head;
        end_of_pass = (j + sde_pkg::CNT_W'(1)) == b_count;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl_a = '0;
    ctl_b = '0;
    if (req_acc) begin
      case (mode)
        sde_pkg::MODE_APP_A: ctl_a.app = 1'b1;
        sde_pkg::MODE_APP_B: ctl_b.app = 1'b1;
        sde_pkg::MODE_CLEAR: begin
          ctl_a.clr = 1'b1;
          ctl_b.clr = 1'b1;
        end
        default: ;
      endcase
    end
    ctl_a.rot = step && (state == S_SCAN_A);
    ctl_b.rot = step && (state == S_SCAN_B);
  end

  sde_chain u_chain_a (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_a),
    .wr_data (element),
    .probe   (b_head),
    .head    (a_head),
    .count   (a_count),
    .full    (a_full),
    .any_hit (a_hit)
  );

  sde_chain u_chain_b (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_b),
    .wr_data (element),
    .probe   (a_head),
    .head    (b_head),
    .count   (b_count),
    .full    (b_full),
    .any_hit (b_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
      sym       <= 1'b0;
      j         <= '0;
    end else begin
      if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            case (mode)
              sde_pkg::MODE_APP_A, sde_pkg::MODE_APP_B: begin
                rsp_valid    <= 1'b1;
                result_value <= '0;
                last         <= 1'b1;
                if ((mode == sde_pkg::MODE_APP_A) ? a_full : b_full) begin
                  status <= sde_pkg::ST_FULL;
                end else begin
                  status <= sde_pkg::ST_APP_OK;
                end
              end
              sde_pkg::MODE_DIFF, sde_pkg::MODE_SYMDIF: begin
                sym    <= mode == sde_pkg::MODE_SYMDIF;
                j      <= '0;
                pend_v <= 1'b0;
                state  <= S_SCAN_A;
              end
              default: ;
            endcase
          end
        end
        S_SCAN_A, S_SCAN_B: begin
          if ((state == S_SCAN_A ? a_count : b_count) == '0) begin
            state <= (state == S_SCAN_A && sym) ? S_SCAN_B : S_FINISH;
            j     <= '0;
          end else if (step) begin
            // a held miss goes out only once a later one proves it is not last
            if (miss) begin
              if (pend_v) begin
                rsp_valid    <= 1'b1;
                result_value <= pend;
                status       <= sde_pkg::ST_ELEM;
                last         <= 1'b0;
              end
              pend   <= cur;
              pend_v <= 1'b1;
            end
            if (end_of_pass) begin
              state <= (state == S_SCAN_A && sym) ? S_SCAN_B : S_FINISH;
              j     <= '0;
            end else begin
              j <= j + sde_pkg::CNT_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            last         <= 1'b1;
            result_value <= pend_v ? pend : '0;
            status       <= pend_v ? sde_pkg::ST_ELEM : sde_pkg::ST_EMPTY;
            pend_v       <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("input taken while a scan is running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= sde_pkg::CNT_W'(sde_pkg::SET_CAPACITY)) &&
    (b_count <= sde_pkg::CNT_W'(sde_pkg::SET_CAPACITY)))
    else $error("set count beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (mode == sde_pkg::MODE_CLEAR)) |=> (a_count == '0) && (b_count == '0))
    else $error("clear did not empty both sets");

  a_non_elem_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != sde_pkg::ST_ELEM)) |-> last)
    else $error("status result not marked last");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_A && a_count != '0) |-> (j < a_count))
    else $error("scan index past set count");

endmodule

[rtl/sde_cell.sv]
// One storage cell of a set chain: holds an element, rotates, compares against a probe.
`timescale 1ns / 1ps

module sde_cell (
  input  logic                          clk,
  input  sde_pkg::cell_ctl_t            ctl,
  input  logic [sde_pkg::IDX_W-1:0]     idx,
  input  logic [sde_pkg::DATA_W-1:0]    wr_data,
  input  logic [sde_pkg::DATA_W-1:0]    from_next,
  input  logic [sde_pkg::DATA_W-1:0]    head,
  input  logic [sde_pkg::DATA_W-1:0]    probe,
  output logic [sde_pkg::DATA_W-1:0]    val,
  output logic                          hit
);

  logic [sde_pkg::CNT_W-1:0] idx_ext;
  logic                      live;
  logic                      wrap;

  assign idx_ext = sde_pkg::CNT_W'(idx);
  assign live    = idx_ext < ctl.count;
  // last occupied cell refills from the head during a rotation
  assign wrap    = (idx_ext + sde_pkg::CNT_W'(1)) == ctl.count;
  assign hit     = live && (val == probe);

  always_ff @(posedge clk) begin
    if (ctl.wr && (idx_ext == ctl.count)) begin
      val <= wr_data;
    end else if (ctl.rot && live) begin
      val <= wrap ? head : from_next;
    end
  end

endmodule

[rtl/sde_chain.sv]
// Row of cells holding one set, with its fill count and membership match.
`timescale 1ns / 1ps

module sde_chain (
  input  logic                          clk,
  input  logic                          rst,
  input  sde_pkg::chain_ctl_t           ctl,
  input  logic [sde_pkg::DATA_W-1:0]    wr_data,
  input  logic [sde_pkg::DATA_W-1:0]    probe,
  output logic [sde_pkg::DATA_W-1:0]    head,
  output logic [sde_pkg::CNT_W-1:0]     count,
  output logic                          full,
  output logic                          any_hit
);

  logic [sde_pkg::DATA_W-1:0]       vals [sde_pkg::SET_CAPACITY];
  logic [sde_pkg::DATA_W-1:0]       nxt  [sde_pkg::SET_CAPACITY];
  logic [sde_pkg::SET_CAPACITY-1:0] hits;
  sde_pkg::cell_ctl_t               cctl;

  assign full    = count == sde_pkg::CNT_W'(sde_pkg::SET_CAPACITY);
  assign head    = vals[0];
  assign any_hit = |hits;

  assign cctl.wr    = ctl.app && !full;
  assign cctl.rot   = ctl.rot;
  assign cctl.count = count;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      count <= '0;
    end else if (ctl.app && !full) begin
      count <= count + sde_pkg::CNT_W'(1);
    end
  end

  for (genvar i = 0; i < sde_pkg::SET_CAPACITY; i++) begin : g_cell
    if (i == sde_pkg::SET_CAPACITY - 1) begin : g_tail
      assign nxt[i] = vals[0];
    end else begin : g_body
      assign nxt[i] = vals[i+1];
    end

    sde_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .idx       (sde_pkg::IDX_W'(i)),
      .wr_data   (wr_data),
      .from_next (nxt[i]),
      .head      (vals[0]),
      .probe     (probe),
      .val       (vals[i]),
      .hit       (hits[i])
    );
  end

endmodule
